FILE: design/background_tile_pixel_fetch_top_macros.svh
// Assertion macros shared by the checker of the background pixel fetch block.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef BACKGROUND_TILE_PIXEL_FETCH_TOP_MACROS_SVH
`define BACKGROUND_TILE_PIXEL_FETCH_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BGTPF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BGTPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/bgtpf_pkg.sv
// Shared types, constants and helpers of the background pixel fetch block.
// Used by every RTL module except the generic RAM, and by the checker; depends on nothing.
package bgtpf_pkg;

  // Video memory geometry: two byte banks, even and odd addresses.
  localparam int VRAM_BYTES   = 8192;
  localparam int VRAM_AW      = $clog2(VRAM_BYTES);
  localparam int BANK_DEPTH   = VRAM_BYTES / 2;
  localparam int BANK_AW      = $clog2(BANK_DEPTH);
  localparam int SCREEN_WIDTH_DEF = 160;

  // Tile map and tile data layout.
  localparam logic [VRAM_AW-1:0] MAP_BASE_LOW       = VRAM_AW'(13'h1800);
  localparam logic [VRAM_AW-1:0] MAP_BANK_STEP      = VRAM_AW'(13'h0400);
  localparam logic [VRAM_AW-1:0] SIGNED_AREA_OFFSET = VRAM_AW'(13'h1000);

  // Control byte bit positions.
  localparam int LCDC_BG_EN    = 0;
  localparam int LCDC_MAP_SEL  = 3;
  localparam int LCDC_TILE_SEL = 4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LCD_CONTROL = 2'd0;
  localparam logic [1:0] CFG_SCROLL_X    = 2'd1;
  localparam logic [1:0] CFG_SCROLL_Y    = 2'd2;
  localparam logic [1:0] CFG_BG_PALETTE  = 2'd3;

  // Request codes.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [12:0] vram_addr;
    logic [7:0]  vram_data;
    logic [7:0]  line;
    logic [7:0]  screen_col;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  shade;
    logic [31:0] argb_color;
  } out_word_t;

  typedef struct packed {
    logic [7:0] lcd_control;
    logic [7:0] scroll_x;
    logic [7:0] scroll_y;
    logic [7:0] bg_palette;
  } cfg_t;

  // Memory request from the fetch sequencer to the banked video memory.
  typedef struct packed {
    logic               wr_en;
    logic [VRAM_AW-1:0] wr_addr;
    logic [7:0]         wr_data;
    logic               rd_en;
    logic [BANK_AW-1:0] rd_word;
  } vram_req_t;

  // Read data of both banks at the requested word.
  typedef struct packed {
    logic [7:0] even;
    logic [7:0] odd;
  } vram_rsp_t;

  // Fixed shade to ARGB table.
  function automatic logic [31:0] shade_argb(input logic [1:0] shade);
    logic [31:0] c;
    unique case (shade)
      2'd0: c = 32'hFFFFFFFF;
      2'd1: c = 32'hFF8080C0;
      2'd2: c = 32'hFF404080;
      2'd3: c = 32'hFF000000;
    endcase
    return c;
  endfunction

endpackage

FILE: design/bgtpf_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; width and depth come from parameters.
module bgtpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Storage and read register; read data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/bgtpf_vram.sv
// Video memory split into an even-address and an odd-address byte bank.
// Depends on bgtpf_pkg and bgtpf_ram; a tile row's two plane bytes are read together.
module bgtpf_vram (
  input  logic                 clk,
  input  bgtpf_pkg::vram_req_t req,
  output bgtpf_pkg::vram_rsp_t rsp
);

  logic                            wr_even;
  logic                            wr_odd;
  logic [bgtpf_pkg::BANK_AW-1:0]   wr_word;

  // Byte address bit 0 picks the bank, the rest is the word inside it.
  assign wr_even = req.wr_en && !req.wr_addr[0];
  assign wr_odd  = req.wr_en &&  req.wr_addr[0];
  assign wr_word = req.wr_addr[bgtpf_pkg::VRAM_AW-1:1];

  bgtpf_ram #(
    .WIDTH (8),
    .DEPTH (bgtpf_pkg::BANK_DEPTH)
  ) u_even (
    .clk     (clk),
    .wr_en   (wr_even),
    .wr_addr (wr_word),
    .wr_data (req.wr_data),
    .rd_en   (req.rd_en),
    .rd_addr (req.rd_word),
    .rd_data (rsp.even)
  );

  bgtpf_ram #(
    .WIDTH (8),
    .DEPTH (bgtpf_pkg::BANK_DEPTH)
  ) u_odd (
    .clk     (clk),
    .wr_en   (wr_odd),
    .wr_addr (wr_word),
    .wr_data (req.wr_data),
    .rd_en   (req.rd_en),
    .rd_addr (req.rd_word),
    .rd_data (rsp.odd)
  );

endmodule

FILE: design/bgtpf_fetch.sv
// Fetch sequencer: map read, tile row read, palette and color lookup, result register.
// Depends on bgtpf_pkg; drives the banked video memory through a request struct.
module bgtpf_fetch #(
  parameter int SCREEN_WIDTH = bgtpf_pkg::SCREEN_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bgtpf_pkg::cfg_t      cfg,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bgtpf_pkg::in_word_t  in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bgtpf_pkg::out_word_t out_word,
  output bgtpf_pkg::vram_req_t mem_req,
  input  bgtpf_pkg::vram_rsp_t mem_rsp
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAP,
    ST_TILE
  } state_t;

  state_t                           state_r, state_nxt;
  logic [2:0]                       fine_row_r, fine_row_nxt;
  logic [2:0]                       fine_col_r, fine_col_nxt;
  logic                             map_odd_r, map_odd_nxt;
  logic                             out_valid_r, out_valid_nxt;
  bgtpf_pkg::out_word_t             out_word_r, out_word_nxt;

  logic                             accept;
  logic                             on_screen;
  logic [7:0]                       bg_row;
  logic [7:0]                       bg_col;
  logic [bgtpf_pkg::VRAM_AW-1:0]    map_addr;
  logic [7:0]                       tile;
  logic [bgtpf_pkg::VRAM_AW-1:0]    tile_addr;
  logic [2:0]                       bit_sel;
  logic [1:0]                       color;
  logic [7:0]                       pal_shift;
  logic [1:0]                       shade;
  logic                             out_free;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Background coordinates wrap at 256; the map entry follows from them.
  assign on_screen = {1'b0, in_word.screen_col} < 9'(SCREEN_WIDTH);
  assign bg_row    = in_word.line + cfg.scroll_y;
  assign bg_col    = in_word.screen_col + cfg.scroll_x;
  assign map_addr  = bgtpf_pkg::MAP_BASE_LOW
                   + (cfg.lcd_control[bgtpf_pkg::LCDC_MAP_SEL] ?
                      bgtpf_pkg::MAP_BANK_STEP : '0)
                   + bgtpf_pkg::VRAM_AW'({bg_row[7:3], bg_col[7:3]});

  // Tile row address from the map byte; low indices sit in the upper area
  // when the tile data select bit is clear.
  assign tile      = map_odd_r ? mem_rsp.odd : mem_rsp.even;
  assign tile_addr = bgtpf_pkg::VRAM_AW'({tile, 4'b0000})
                   + ((!cfg.lcd_control[bgtpf_pkg::LCDC_TILE_SEL] && !tile[7]) ?
                      bgtpf_pkg::SIGNED_AREA_OFFSET : '0)
                   + bgtpf_pkg::VRAM_AW'({fine_row_r, 1'b0});

  // Pixel color from the two plane bytes, leftmost pixel in bit 7.
  assign bit_sel   = ~fine_col_r;
  assign color     = {mem_rsp.odd[bit_sel], mem_rsp.even[bit_sel]};
  assign pal_shift = cfg.bg_palette >> {color, 1'b0};
  assign shade     = cfg.lcd_control[bgtpf_pkg::LCDC_BG_EN] ? pal_shift[1:0] : 2'd0;

  // Memory requests: writes and map reads start in idle, tile reads follow the map.
  always_comb begin
    mem_req         = '0;
    mem_req.wr_addr = in_word.vram_addr;
    mem_req.wr_data = in_word.vram_data;
    mem_req.rd_word = map_addr[bgtpf_pkg::VRAM_AW-1:1];
    unique case (state_r)
      ST_IDLE: begin
        mem_req.wr_en = accept && (in_word.req_type == bgtpf_pkg::REQ_WRITE);
        mem_req.rd_en = accept && (in_word.req_type == bgtpf_pkg::REQ_PIXEL) && on_screen;
      end
      ST_MAP: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_word = tile_addr[bgtpf_pkg::VRAM_AW-1:1];
      end
      ST_TILE: begin
        mem_req.rd_en = 1'b0;
      end
    endcase
  end

  // Next state, pixel position and result register.
  always_comb begin
    state_nxt     = state_r;
    fine_row_nxt  = fine_row_r;
    fine_col_nxt  = fine_col_r;
    map_odd_nxt   = map_odd_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_word.req_type == bgtpf_pkg::REQ_PIXEL) && on_screen) begin
          state_nxt    = ST_MAP;
          fine_row_nxt = bg_row[2:0];
          fine_col_nxt = bg_col[2:0];
          map_odd_nxt  = map_addr[0];
        end
      end
      ST_MAP: begin
        state_nxt = ST_TILE;
      end
      ST_TILE: begin
        if (out_free) begin
          state_nxt               = ST_IDLE;
          out_valid_nxt           = 1'b1;
          out_word_nxt.shade      = shade;
          out_word_nxt.argb_color = bgtpf_pkg::shade_argb(shade);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    fine_row_r <= fine_row_nxt;
    fine_col_r <= fine_col_nxt;
    map_odd_r  <= map_odd_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

FILE: design/background_tile_pixel_fetch_top.sv
// Background tile pixel fetch: top level with configuration registers.
// A memory write word or an off-screen query leaves the input open; a pixel query runs
// a map read, then a tile row read, then the result register, set by the dependent video
// memory reads, and holds off input until its result is registered, also while stalled.
// Synchronous active-low reset clears the registers and control; memory is not cleared.
// Depends on bgtpf_pkg, bgtpf_fetch and bgtpf_vram.
module background_tile_pixel_fetch_top #(
  parameter int SCREEN_WIDTH = bgtpf_pkg::SCREEN_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bgtpf_pkg::in_word_t  in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bgtpf_pkg::out_word_t out_word
);

  bgtpf_pkg::cfg_t      cfg_r;
  bgtpf_pkg::vram_req_t mem_req;
  bgtpf_pkg::vram_rsp_t mem_rsp;

  // Configuration registers, written by index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        bgtpf_pkg::CFG_LCD_CONTROL: cfg_r.lcd_control <= cfg_data;
        bgtpf_pkg::CFG_SCROLL_X:    cfg_r.scroll_x    <= cfg_data;
        bgtpf_pkg::CFG_SCROLL_Y:    cfg_r.scroll_y    <= cfg_data;
        bgtpf_pkg::CFG_BG_PALETTE:  cfg_r.bg_palette  <= cfg_data;
      endcase
    end
  end

  bgtpf_fetch #(
    .SCREEN_WIDTH (SCREEN_WIDTH)
  ) u_fetch (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .mem_req   (mem_req),
    .mem_rsp   (mem_rsp)
  );

  bgtpf_vram u_vram (
    .clk (clk),
    .req (mem_req),
    .rsp (mem_rsp)
  );

endmodule

FILE: design/bgtpf_checker.sv
// Port-level checker for the background pixel fetch block, bound to the top level.
// Depends on bgtpf_pkg and the assertion macro header.
`include "background_tile_pixel_fetch_top_macros.svh"

module bgtpf_checker #(
  parameter int SCREEN_WIDTH = bgtpf_pkg::SCREEN_WIDTH_DEF
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input bgtpf_pkg::in_word_t  in_word,
  input logic                 out_valid,
  input logic                 out_stall,
  input bgtpf_pkg::out_word_t out_word
);

  logic in_acc;
  logic pix_acc;
  logic wr_acc;

  assign in_acc  = in_valid && !in_stall;
  assign pix_acc = in_acc && (in_word.req_type == bgtpf_pkg::REQ_PIXEL)
                && ({1'b0, in_word.screen_col} < 9'(SCREEN_WIDTH));
  assign wr_acc  = in_acc && (in_word.req_type == bgtpf_pkg::REQ_WRITE);

  // A result word waiting on the output stays there.
  `BGTPF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result word dropped while stalled")

  // The color always follows the shade through the fixed table.
  `BGTPF_ASSERT_NOW(a_argb_match, clk, rst_n, out_valid, out_word.argb_color == bgtpf_pkg::shade_argb(out_word.shade), "color does not match shade")

  // An on-screen query occupies the block while its reads are under way.
  `BGTPF_ASSERT_NEXT(a_query_busy, clk, rst_n, pix_acc, in_stall, "query did not hold off input")

  // A memory write completes at once, so the input stays open behind it.
  `BGTPF_ASSERT_NEXT(a_write_free, clk, rst_n, wr_acc, !in_stall, "write held off input")

endmodule

bind background_tile_pixel_fetch_top bgtpf_checker #(
  .SCREEN_WIDTH (SCREEN_WIDTH)
) u_bgtpf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

FILE: test/tb_top.sv
// Self-checking testbench for the background tile pixel fetch block.
// It predicts every pixel from its own copy of video memory and registers.
// Depends on bgtpf_pkg and background_tile_pixel_fetch_top.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCREEN_W = bgtpf_pkg::SCREEN_WIDTH_DEF;
  localparam int PHASE_WORDS = 53;
  localparam logic [3:0][31:0] SHADE_COLORS = {
    32'hFF000000, 32'hFF404080, 32'hFF8080C0, 32'hFFFFFFFF
  };

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [1:0]           cfg_index = bgtpf_pkg::CFG_LCD_CONTROL;
  logic [7:0]           cfg_data = 8'h00;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  bgtpf_pkg::in_word_t  in_word = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  bgtpf_pkg::out_word_t out_word;

  // Words waiting for the driver, and pixels waiting for the monitor.
  bgtpf_pkg::in_word_t  pending_words[$];
  bgtpf_pkg::out_word_t expected_pixels[$];
  bgtpf_pkg::out_word_t want_pixel;
  int                   error_count = 0;
  int                   queued_count = 0;

  // Register copy and video memory as seen by accepted words.
  bgtpf_pkg::cfg_t cur_cfg = '0;
  logic [7:0]      pred_vram [bgtpf_pkg::VRAM_BYTES];

  // Video memory contents as seen by the stimulus generator, which runs ahead.
  logic [7:0] gen_vram [bgtpf_pkg::VRAM_BYTES];
  bit         gen_written [bgtpf_pkg::VRAM_BYTES];

  // Sender burst and receiver stall state.
  bit sender_bursty = 1'b1;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_mode_left = 0;
  int stall_tick = 0;

  background_tile_pixel_fetch_top #(
    .SCREEN_WIDTH(SCREEN_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Tile map address of a screen pixel under the current scroll and map select.
  function automatic logic [12:0] map_addr_of(input logic [7:0] qline,
                                              input logic [7:0] qcol);
    logic [7:0] bg_row;
    logic [7:0] bg_col;
    bg_row = qline + cur_cfg.scroll_y;
    bg_col = qcol + cur_cfg.scroll_x;
    return bgtpf_pkg::MAP_BASE_LOW
         + (cur_cfg.lcd_control[bgtpf_pkg::LCDC_MAP_SEL] ?
            bgtpf_pkg::MAP_BANK_STEP : 13'h0000)
         + {3'b000, bg_row[7:3], bg_col[7:3]};
  endfunction

  // Address of the low plane byte of the tile row that a screen line hits.
  function automatic logic [12:0] tile_row_addr_of(input logic [7:0] tile,
                                                   input logic [7:0] qline);
    logic [7:0]  bg_row;
    logic [12:0] base;
    bg_row = qline + cur_cfg.scroll_y;
    base = {1'b0, tile, 4'b0000};
    // Low tile indexes live in the upper data area unless tile select is set.
    if (!cur_cfg.lcd_control[bgtpf_pkg::LCDC_TILE_SEL] && !tile[7]) begin
      base = base + bgtpf_pkg::SIGNED_AREA_OFFSET;
    end
    return base + {9'd0, bg_row[2:0], 1'b0};
  endfunction

  // Background pixel of one on-screen query.
  function automatic bgtpf_pkg::out_word_t predict_pixel(input logic [7:0] qline,
                                                         input logic [7:0] qcol);
    logic [12:0]          taddr;
    logic [7:0]           plane_lo;
    logic [7:0]           plane_hi;
    logic [7:0]           bg_col;
    logic [2:0]           bit_sel;
    logic [1:0]           color;
    logic [1:0]           shade;
    bgtpf_pkg::out_word_t pix;
    taddr = tile_row_addr_of(pred_vram[map_addr_of(qline, qcol)], qline);
    plane_lo = pred_vram[taddr];
    plane_hi = pred_vram[taddr + 13'd1];
    bg_col = qcol + cur_cfg.scroll_x;
    bit_sel = 3'd7 - bg_col[2:0];
    color = {plane_hi[bit_sel], plane_lo[bit_sel]};
    shade = cur_cfg.bg_palette[{color, 1'b0} +: 2];
    // A disabled background always shows the lightest shade.
    if (!cur_cfg.lcd_control[bgtpf_pkg::LCDC_BG_EN]) begin
      shade = 2'd0;
    end
    pix.shade = shade;
    pix.argb_color = SHADE_COLORS[shade];
    return pix;
  endfunction

  // Update the predicted memory, or queue the pixel that a query will return.
  task automatic apply_accepted_word(input bgtpf_pkg::in_word_t w);
    if (w.req_type == bgtpf_pkg::REQ_WRITE) begin
      pred_vram[w.vram_addr] = w.vram_data;
    end else if (w.screen_col < SCREEN_W) begin
      expected_pixels.push_back(predict_pixel(w.line, w.screen_col));
    end
  endtask

  // Queue one memory write word; the pixel fields carry random noise.
  task automatic queue_write(input logic [12:0] addr, input logic [7:0] data);
    bgtpf_pkg::in_word_t w;
    w.req_type = bgtpf_pkg::REQ_WRITE;
    w.vram_addr = addr;
    w.vram_data = data;
    w.line = 8'($urandom_range(0, 255));
    w.screen_col = 8'($urandom_range(0, 255));
    pending_words.push_back(w);
    gen_vram[addr] = data;
    gen_written[addr] = 1'b1;
    queued_count++;
  endtask

  // Queue a pixel query, preceded by the writes that make every byte it reads
  // defined. A non-negative force_tile overwrites the map entry first.
  task automatic queue_pixel(input logic [7:0] qline, input logic [7:0] qcol,
                             input int force_tile);
    logic [12:0]         maddr;
    logic [12:0]         taddr;
    logic [7:0]          tile;
    bgtpf_pkg::in_word_t w;
    if (qcol < SCREEN_W) begin
      maddr = map_addr_of(qline, qcol);
      if (force_tile >= 0) begin
        queue_write(maddr, 8'(force_tile));
      end else if (!gen_written[maddr]) begin
        // Favor the tile indexes on either side of the data area split.
        case ($urandom_range(0, 5))
          0: tile = 8'h7F;
          1: tile = 8'h80;
          2: tile = 8'h00;
          3: tile = 8'hFF;
          default: tile = 8'($urandom_range(0, 255));
        endcase
        queue_write(maddr, tile);
      end
      taddr = tile_row_addr_of(gen_vram[maddr], qline);
      if (!gen_written[taddr]) begin
        queue_write(taddr, 8'($urandom_range(0, 255)));
      end
      if (!gen_written[taddr + 13'd1]) begin
        queue_write(taddr + 13'd1, 8'($urandom_range(0, 255)));
      end
    end
    w.req_type = bgtpf_pkg::REQ_PIXEL;
    w.vram_addr = 13'($urandom_range(0, bgtpf_pkg::VRAM_BYTES - 1));
    w.vram_data = 8'($urandom_range(0, 255));
    w.line = qline;
    w.screen_col = qcol;
    pending_words.push_back(w);
    queued_count++;
  endtask

  // One register write on the configuration port.
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      bgtpf_pkg::CFG_LCD_CONTROL: cur_cfg.lcd_control = val;
      bgtpf_pkg::CFG_SCROLL_X:    cur_cfg.scroll_x = val;
      bgtpf_pkg::CFG_SCROLL_Y:    cur_cfg.scroll_y = val;
      bgtpf_pkg::CFG_BG_PALETTE:  cur_cfg.bg_palette = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] lcdc, input logic [7:0] sx,
                            input logic [7:0] sy, input logic [7:0] pal);
    write_reg(bgtpf_pkg::CFG_LCD_CONTROL, lcdc);
    write_reg(bgtpf_pkg::CFG_SCROLL_X, sx);
    write_reg(bgtpf_pkg::CFG_SCROLL_Y, sy);
    write_reg(bgtpf_pkg::CFG_BG_PALETTE, pal);
  endtask

  // Hold until every word is taken and every pixel has come back, then let
  // a trailing write or off-screen query leave the pipeline.
  task automatic wait_drained;
    while (pending_words.size() != 0 || in_valid || expected_pixels.size() != 0) begin
      @(posedge clk);
    end
    repeat (5) @(posedge clk);
  endtask

  // Driver: sends queued words in bursts separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_accepted_word(in_word);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          in_word <= pending_words.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left = burst_left - 1;
          end else begin
            burst_left = $urandom_range(0, 20);
            gap_left = sender_bursty ? $urandom_range(0, 10) : 0;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: switches among none, light, heavy and periodic stalling.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_mode_left = $urandom_range(20, 80);
      end else begin
        stall_mode_left = stall_mode_left - 1;
      end
      stall_tick = stall_tick + 1;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= stall_tick[2];
      endcase
    end
  end

  // Monitor: compares each accepted result word with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected result word: shade %0d argb_color %h",
               out_word.shade, out_word.argb_color);
        error_count++;
      end else begin
        want_pixel = expected_pixels.pop_front();
        if (out_word.shade !== want_pixel.shade) begin
          $error("shade mismatch: expected %0d, actual %0d",
                 want_pixel.shade, out_word.shade);
          error_count++;
        end
        if (out_word.argb_color !== want_pixel.argb_color) begin
          $error("argb_color mismatch: expected %h, actual %h",
                 want_pixel.argb_color, out_word.argb_color);
          error_count++;
        end
      end
    end
  end

  // Stimulus: directed corners first, then randomly configured phases.
  initial begin
    int start_count;
    int pick;
    logic [7:0] lcdc;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Background on, map 0, split tile data area, identity palette.
    set_config(8'h01, 8'h00, 8'h00, 8'hE4);
    queue_write(13'h0000, 8'hFF);
    queue_write(13'h1FFF, 8'h00);
    queue_pixel(8'd0, 8'd0, 8'h00);
    queue_pixel(8'd143, 8'd159, 8'h7F);
    queue_pixel(8'd255, 8'd100, 8'h80);
    queue_pixel(8'd200, 8'd8, 8'hFF);
    queue_pixel(8'd10, 8'd160, -1);
    queue_pixel(8'd255, 8'd255, -1);
    wait_drained();

    // Background off with the darkest palette, map 1, maximum scroll.
    set_config(8'h1E, 8'hFF, 8'hFF, 8'hFF);
    queue_pixel(8'd0, 8'd0, -1);
    queue_pixel(8'd143, 8'd159, -1);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      if (p == 0) begin
        set_config(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      end else if (p == 1) begin
        set_config(8'h00, 8'h00, 8'h00, 8'h00);
      end else begin
        lcdc = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) != 0) begin
          lcdc[bgtpf_pkg::LCDC_BG_EN] = 1'b1;
        end
        set_config(lcdc, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
      end
      sender_bursty = (p != 2) && ($urandom_range(0, 4) != 0);

      // Mostly well-formed queries, with off-screen queries and stray writes.
      start_count = queued_count;
      while (queued_count - start_count < PHASE_WORDS) begin
        pick = $urandom_range(0, 99);
        if (pick < 62) begin
          queue_pixel(($urandom_range(0, 6) == 0) ? 8'($urandom_range(144, 255))
                                                  : 8'($urandom_range(0, 143)),
                      8'($urandom_range(0, SCREEN_W - 1)), -1);
        end else if (pick < 72) begin
          queue_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(SCREEN_W, 255)), -1);
        end else if (pick < 86) begin
          queue_write(13'($urandom_range(32'h1800, 32'h1FFF)), 8'($urandom_range(0, 255)));
        end else begin
          queue_write(13'($urandom_range(0, bgtpf_pkg::VRAM_BYTES - 1)),
                      8'($urandom_range(0, 255)));
        end
      end
      wait_drained();
    end

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
